// ===== rtl/core/srsw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the sender window.
package srsw_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int SEQ_MODULUS = 32;
  localparam int TIME_BITS   = 16;

  localparam int SLOT_W    = $clog2(WINDOW_SIZE);
  localparam int COUNT_W   = $clog2(WINDOW_SIZE + 1);
  localparam int SEQ_W     = $clog2(SEQ_MODULUS);
  localparam int TIMEOUT_W = 15;
  localparam int CMD_W     = 2;
  localparam int ACT_W     = 3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2
  } srsw_cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_SENT    = 3'd1,
    ACT_REFUSED = 3'd2,
    ACT_TAKEN   = 3'd3,
    ACT_IGNORED = 3'd4,
    ACT_RESENT  = 3'd5
  } srsw_action_e;

  typedef struct packed {
    logic exec;
    logic retire_step;
    logic retire_end;
    logic seek_step;
    logic seek_end;
    logic load_out;
  } srsw_ctrl_t;

  typedef struct packed {
    logic retire_pend;
    logic retire_more;
    logic seek_pend;
    logic seek_more;
    logic out_free;
  } srsw_status_t;

endpackage

// ===== rtl/core/srsw_dp.sv =====
// Datapath of the sender window: window state, send time ring, timer and result register.
module srsw_dp import srsw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srsw_ctrl_t           ctrl_i,
  output srsw_status_t         status_o,
  input  logic [CMD_W-1:0]     in_cmd_i,
  input  logic [SEQ_W-1:0]     in_ack_i,
  input  logic                 cfg_we_i,
  input  logic [TIMEOUT_W-1:0] cfg_wdata_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [ACT_W-1:0]     out_action_o,
  output logic [SEQ_W-1:0]     out_seq_o,
  output logic [COUNT_W-1:0]   out_in_flight_o
);

  logic [WINDOW_SIZE-1:0] acked_q, acked_d;
  logic [TIME_BITS-1:0]   tq_q [WINDOW_SIZE];
  logic [SLOT_W-1:0]      head_q, head_d;
  logic [SLOT_W-1:0]      tq_head_q, tq_head_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [SEQ_W-1:0]       base_q, base_d;
  logic [SEQ_W-1:0]       next_q, next_d;
  logic [SLOT_W-1:0]      scan_q, scan_d;
  logic [COUNT_W-1:0]     tries_q, tries_d;
  logic [TIME_BITS-1:0]   now_q, now_d;
  logic [TIMEOUT_W-1:0]   timeout_q, timeout_d;
  logic [ACT_W-1:0]       act_q, act_d;
  logic [SEQ_W-1:0]       seq_q, seq_d;
  logic                   ret_pend_q, ret_pend_d;
  logic                   seek_pend_q, seek_pend_d;
  logic                   out_valid_q, out_valid_d;
  logic [ACT_W-1:0]       out_act_q, out_act_d;
  logic [SEQ_W-1:0]       out_seq_q, out_seq_d;
  logic [COUNT_W-1:0]     out_cnt_q, out_cnt_d;

  logic                   tq_we;
  logic [SLOT_W-1:0]      tq_waddr;
  logic [TIME_BITS-1:0]   tq_wdata;

  logic [TIME_BITS-1:0]   now_inc;
  logic [TIME_BITS-1:0]   elapsed;
  logic                   timed_out;
  logic [SEQ_W-1:0]       ack_off;
  logic                   ack_found;
  logic [SLOT_W-1:0]      ack_slot;
  logic [SLOT_W-1:0]      tail_slot;
  logic [SLOT_W-1:0]      tail_tq;
  logic [SLOT_W-1:0]      scan_slot;
  logic [SLOT_W-1:0]      scan_next;
  logic                   full;

  assign now_inc   = now_q + TIME_BITS'(1);
  assign elapsed   = now_inc - tq_q[tq_head_q];
  assign timed_out = (count_q != '0) && (elapsed >= TIME_BITS'(timeout_q));
  assign ack_off   = in_ack_i - base_q;
  assign ack_found = ack_off < SEQ_W'(count_q);
  assign ack_slot  = head_q + ack_off[SLOT_W-1:0];
  assign tail_slot = head_q + count_q[SLOT_W-1:0];
  assign tail_tq   = tq_head_q + count_q[SLOT_W-1:0];
  assign scan_slot = head_q + scan_q;
  assign scan_next = ((COUNT_W'(scan_q) + COUNT_W'(1)) == count_q) ? '0 : scan_q + SLOT_W'(1);
  assign full      = count_q >= COUNT_W'(WINDOW_SIZE);

  always_comb begin
    acked_d     = acked_q;
    head_d      = head_q;
    tq_head_d   = tq_head_q;
    count_d     = count_q;
    base_d      = base_q;
    next_d      = next_q;
    scan_d      = scan_q;
    tries_d     = tries_q;
    now_d       = now_q;
    act_d       = act_q;
    seq_d       = seq_q;
    ret_pend_d  = ret_pend_q;
    seek_pend_d = seek_pend_q;
    out_valid_d = out_valid_q;
    out_act_d   = out_act_q;
    out_seq_d   = out_seq_q;
    out_cnt_d   = out_cnt_q;
    tq_we       = 1'b0;
    tq_waddr    = tail_tq;
    tq_wdata    = now_q;
    timeout_d   = cfg_we_i ? cfg_wdata_i : timeout_q;

    if (ctrl_i.exec) begin
      act_d       = ACT_NONE;
      seq_d       = '0;
      ret_pend_d  = 1'b0;
      seek_pend_d = 1'b0;
      tries_d     = '0;
      case (in_cmd_i)
        CMD_SEND: begin
          if (full) begin
            act_d = ACT_REFUSED;
          end else begin
            acked_d[tail_slot] = 1'b0;
            tq_we              = 1'b1;
            count_d            = count_q + COUNT_W'(1);
            seq_d              = next_q;
            next_d             = next_q + SEQ_W'(1);
            act_d              = ACT_SENT;
          end
        end
        CMD_ACK: begin
          seq_d = in_ack_i;
          if (!ack_found) begin
            act_d = ACT_IGNORED;
          end else begin
            act_d             = ACT_TAKEN;
            acked_d[ack_slot] = 1'b1;
            ret_pend_d        = (in_ack_i == base_q);
            seek_pend_d       = 1'b1;
          end
        end
        CMD_TICK: begin
          now_d = now_inc;
          if (timed_out) begin
            // drop the front time, append the current one at the old tail
            seq_d       = base_q + SEQ_W'(scan_q);
            tq_head_d   = tq_head_q + SLOT_W'(1);
            tq_we       = 1'b1;
            tq_wdata    = now_inc;
            scan_d      = scan_next;
            seek_pend_d = 1'b1;
            act_d       = ACT_RESENT;
          end
        end
        default: begin
        end
      endcase
    end

    if (ctrl_i.retire_step) begin
      acked_d[head_q] = 1'b0;
      head_d          = head_q + SLOT_W'(1);
      tq_head_d       = tq_head_q + SLOT_W'(1);
      count_d         = count_q - COUNT_W'(1);
      base_d          = base_q + SEQ_W'(1);
    end

    if (ctrl_i.retire_end) begin
      scan_d     = '0;
      ret_pend_d = 1'b0;
    end

    if (ctrl_i.seek_step) begin
      scan_d  = scan_next;
      tries_d = tries_q + COUNT_W'(1);
    end

    if (ctrl_i.seek_end) begin
      if (count_q == '0) begin
        scan_d = '0;
      end
      seek_pend_d = 1'b0;
    end

    if (ctrl_i.load_out) begin
      out_valid_d = 1'b1;
      out_act_d   = act_q;
      out_seq_d   = seq_q;
      out_cnt_d   = count_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q     <= '0;
      head_q      <= '0;
      tq_head_q   <= '0;
      count_q     <= '0;
      base_q      <= '0;
      next_q      <= '0;
      scan_q      <= '0;
      tries_q     <= '0;
      now_q       <= '0;
      timeout_q   <= TIMEOUT_RESET;
      ret_pend_q  <= 1'b0;
      seek_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acked_q     <= acked_d;
      head_q      <= head_d;
      tq_head_q   <= tq_head_d;
      count_q     <= count_d;
      base_q      <= base_d;
      next_q      <= next_d;
      scan_q      <= scan_d;
      tries_q     <= tries_d;
      now_q       <= now_d;
      timeout_q   <= timeout_d;
      ret_pend_q  <= ret_pend_d;
      seek_pend_q <= seek_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    seq_q     <= seq_d;
    out_act_q <= out_act_d;
    out_seq_q <= out_seq_d;
    out_cnt_q <= out_cnt_d;
    if (tq_we) begin
      tq_q[tq_waddr] <= tq_wdata;
    end
  end

  assign status_o.retire_pend = ret_pend_q;
  assign status_o.retire_more = (count_q != '0) && acked_q[head_q];
  assign status_o.seek_pend   = seek_pend_q;
  assign status_o.seek_more   = (count_q != '0) && acked_q[scan_slot] && (tries_q < count_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_action_o    = out_act_q;
  assign out_seq_o       = out_seq_q;
  assign out_in_flight_o = out_cnt_q;

endmodule

// ===== rtl/core/srsw_ctrl.sv =====
// Controller of the sender window: sequences execute, retire, pointer search and result load.
module srsw_ctrl import srsw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  srsw_status_t status_i,
  output srsw_ctrl_t   ctrl_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RETIRE = 4'b0010,
    ST_SEEK   = 4'b0100,
    ST_DONE   = 4'b1000
  } srsw_state_e;

  srsw_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.exec = 1'b1;
          state_d     = ST_RETIRE;
        end
      end
      ST_RETIRE: begin
        if (status_i.retire_pend) begin
          if (status_i.retire_more) begin
            ctrl_o.retire_step = 1'b1;
          end else begin
            ctrl_o.retire_end = 1'b1;
          end
        end else begin
          state_d = ST_SEEK;
        end
      end
      ST_SEEK: begin
        if (status_i.seek_pend) begin
          if (status_i.seek_more) begin
            ctrl_o.seek_step = 1'b1;
          end else begin
            ctrl_o.seek_end = 1'b1;
          end
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/core/selective_repeat_sender_window.sv =====
// After execute, the controller retires acked slots in RETIRE and searches for an unacked slot in SEEK.
// Throughput: one word at a time; the next word is taken once the previous result is loaded.
// One result word is held, so a stalled output lets one more word in; its result then waits in DONE.
// Reset: asynchronous, active low; empty window, clock at zero, timeout back to 100 ticks.
// The send time ring is not cleared; only entries inside the window are ever read.
module selective_repeat_sender_window import srsw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [4:0] ack_seq
  input  logic [CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [4:0] seq, [8:5] in_flight
  output logic [ACT_W-1:0]     m_axis_tuser,   // [2:0] action
  input  logic                 cfg_we_i,
  input  logic [TIMEOUT_W-1:0] cfg_wdata_i
);

  srsw_ctrl_t         ctrl;
  srsw_status_t       status;
  logic [SEQ_W-1:0]   out_seq;
  logic [COUNT_W-1:0] out_in_flight;

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  srsw_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .in_cmd_i        (s_axis_tuser),
    .in_ack_i        (s_axis_tdata[SEQ_W-1:0]),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_action_o    (m_axis_tuser),
    .out_seq_o       (out_seq),
    .out_in_flight_o (out_in_flight)
  );

  assign m_axis_tdata = {(16 - SEQ_W - COUNT_W)'(0), out_in_flight, out_seq};

endmodule

// ===== rtl/core/srsw_checker.sv =====
// Port checker of the sender window and its binding to the top level.
module srsw_checker import srsw_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [15:0]          m_axis_tdata,
  input logic [ACT_W-1:0]     m_axis_tuser
);

  logic [COUNT_W-1:0] in_flight;
  assign in_flight = m_axis_tdata[SEQ_W+COUNT_W-1:SEQ_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> in_flight <= COUNT_W'(WINDOW_SIZE))
    else $error("in_flight above window size");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_REFUSED) |->
      in_flight == COUNT_W'(WINDOW_SIZE) && m_axis_tdata[SEQ_W-1:0] == '0)
    else $error("refusal with window not full");

  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_SENT || m_axis_tuser == ACT_RESENT) |->
      in_flight != '0)
    else $error("send or resend reported with empty window");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken before result was produced");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
